// ----- hw/rtl/sss_pkg.sv -----
`default_nettype none

package sss_pkg;

    localparam int TEXT_W = 56;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FIRST,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/short_string_selection_sort.sv -----
// short_string_selection_sort
// Collects text lines of up to MAX_CHARS bytes (first character in the top byte,
// zero padded) and emits them in ascending order on a finish command.
// s_axis: tuser is the command (load or finish), tdata the 56-bit line.
// m_axis: tdata is a sorted line, tlast marks the final line of the run,
// tuser is set on every line of a batch where loads beyond MAX_LINES were lost.
// A load gives no output beat. A finish with n stored lines
// holds s_axis_tready low while the lines are sorted out of the line memory:
// pass i reads the remaining n-i entries one per cycle through the single read
// port and then emits the minimum. A finish with no lines gives no beat.
// The output beat sits in a register; while the receiver stalls, the next pass
// waits in its emit step and resumes when the register frees.
// Reset empties the store and clears the overflow flag; the line memory itself
// is not cleared, since only entries below the line count are ever read.
`default_nettype none

module short_string_selection_sort #(
    parameter int MAX_LINES = 16,
    parameter int MAX_CHARS = 7
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire  [sss_pkg::TEXT_W-1:0] s_axis_tdata,   // line_text
    input  wire                        s_axis_tuser,   // cmd
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [sss_pkg::TEXT_W-1:0] m_axis_tdata,   // sorted_text
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser    // lines_dropped
);

    import sss_pkg::*;

    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int AW = $clog2(MAX_LINES);

    function automatic logic [TEXT_W-1:0] clip_line(input logic [TEXT_W-1:0] text);
        logic [63:0] wide;
        logic [63:0] keep;
        logic        stop;
        wide = {8'h00, text};
        keep = '0;
        stop = 1'b0;
        for (int k = 0; k < MAX_CHARS; k++)
        begin
            if (!stop)
            begin
                if (wide[8*(MAX_CHARS-1-k) +: 8] == 8'h00)
                    stop = 1'b1;
                else
                    keep[8*(MAX_CHARS-1-k) +: 8] = wide[8*(MAX_CHARS-1-k) +: 8];
            end
        end
        return keep[TEXT_W-1:0];
    endfunction

    logic [TEXT_W-1:0] line_mem [MAX_LINES];

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]     best_reg, best_next;
    logic [TEXT_W-1:0] min_reg, min_next;
    logic [TEXT_W-1:0] cur_reg, cur_next;
    logic              fwd_reg, fwd_next;
    logic [TEXT_W-1:0] rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    logic [TEXT_W-1:0] out_text_reg, out_text_next;
    logic              out_last_reg, out_last_next;
    logic              out_drop_reg, out_drop_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [TEXT_W-1:0] mem_wdata;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              out_free;
    logic              last_pass;
    logic              in_beat;
    logic [TEXT_W-1:0] first_val;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last_pass = (CW'(i_reg) + CW'(1)) == count_reg;
    assign first_val = fwd_reg ? cur_reg : rd_data_reg;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_text_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_drop_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_next      = best_reg;
        min_next       = min_reg;
        cur_next       = cur_reg;
        fwd_next       = fwd_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_text_next  = out_text_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = clip_line(s_axis_tdata);
        rd_en          = 1'b0;
        rd_addr        = j_reg[AW-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    if (s_axis_tuser == CMD_LOAD)
                    begin
                        if (count_reg < CW'(MAX_LINES))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else if (count_reg == '0)
                        ovf_next = 1'b0;
                    else
                    begin
                        i_next     = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        j_next     = CW'(1);
                        fwd_next   = 1'b0;
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST:
            begin
                cur_next  = first_val;
                min_next  = first_val;
                best_next = i_reg;
                if (j_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = j_reg[AW-1:0];
                    cmp_idx_next = j_reg[AW-1:0];
                    j_next       = j_reg + CW'(1);
                    state_next   = ST_SCAN;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_SCAN:
            begin
                if (rd_data_reg < min_reg)
                begin
                    min_next  = rd_data_reg;
                    best_next = cmp_idx_reg;
                end
                if (j_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = j_reg[AW-1:0];
                    cmp_idx_next = j_reg[AW-1:0];
                    j_next       = j_reg + CW'(1);
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_text_next  = min_reg;
                    out_last_next  = last_pass;
                    out_drop_next  = ovf_reg;
                    // old entry i moves to where the minimum was
                    mem_we         = 1'b1;
                    mem_waddr      = best_reg;
                    mem_wdata      = cur_reg;
                    if (last_pass)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        rd_en      = 1'b1;
                        rd_addr    = i_reg + AW'(1);
                        j_next     = CW'(i_reg) + CW'(2);
                        // read and write of the same entry on one edge
                        fwd_next   = (best_reg == i_reg + AW'(1));
                        state_next = ST_FIRST;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        min_reg      <= min_next;
        cur_reg      <= cur_next;
        fwd_reg      <= fwd_next;
        out_text_reg <= out_text_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LINES))
        else $error("line count beyond capacity");

    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (CW'(i_reg) < count_reg))
        else $error("pass index outside stored lines");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CW'(cmp_idx_reg) < count_reg && cmp_idx_reg > i_reg))
        else $error("scan address outside remaining lines");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && last_pass)
        |=> (state_reg == ST_LOAD && count_reg == '0 && !ovf_reg
             && m_axis_tvalid && m_axis_tlast))
        else $error("store not emptied after final line");

endmodule

`default_nettype wire
